[src/aide_pkg.sv]
// Shared codes and command types for the array insert/delete engine.
// Used by aide_dp, aide_ctrl and array_insert_delete_engine_core; depends on nothing.
package aide_pkg;

  localparam int KIND_W   = 2;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 5;
  localparam int STATUS_W = 3;
  localparam int EIDX_W   = 4;
  localparam int FILL_W   = 5;

  localparam logic [KIND_W-1:0] KIND_DUMP   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DONE      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ENTRY     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd5;

  localparam logic [1:0] OP_NONE   = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;
  localparam logic [1:0] OP_ROTATE = 2'd3;

  typedef struct packed {
    logic [1:0]       op;
    logic [POS_W-1:0] position;
  } cmd_t;

  typedef struct packed {
    logic found;
    logic empty;
    logic full;
  } flags_t;

endpackage

[src/aide_dp.sv]
// Datapath: a row of shifting storage cells with the fill count and the parallel match logic.
// Depends on aide_pkg for the command and flag types.
module aide_dp #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32,
  parameter int CW         = 5,
  parameter int IW         = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  aide_pkg::cmd_t                cmd,
  input  logic [aide_pkg::VALUE_W-1:0]  value,
  output aide_pkg::flags_t              flags,
  output logic [CW-1:0]                 count,
  output logic [IW-1:0]                 match_idx,
  output logic [DATA_WIDTH-1:0]         head
);

  logic [DATA_WIDTH-1:0] cells      [DEPTH];
  logic [DATA_WIDTH-1:0] cells_next [DEPTH];
  logic [DATA_WIDTH-1:0] val_w;
  logic [DEPTH-1:0]      match;
  logic [DEPTH-1:0]      first;
  logic [DEPTH-1:0]      lowmask;
  logic [CW-1:0]         count_next;

  assign val_w   = DATA_WIDTH'($unsigned(value));
  assign first   = match & (~match + DEPTH'(1));
  assign lowmask = first - DEPTH'(1);
  assign head    = cells[0];

  assign flags.found = |match;
  assign flags.empty = (count == '0);
  assign flags.full  = (count == CW'(DEPTH));

  always_comb begin
    match_idx = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (first[i]) begin
        match_idx = match_idx | IW'(i);
      end
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign match[i] = (cells[i] == val_w) && (int'(count) > i);

    always_comb begin
      cells_next[i] = cells[i];
      unique case (cmd.op)
        aide_pkg::OP_INSERT: begin
          if (int'(cmd.position) == i) begin
            cells_next[i] = val_w;
          end else if (int'(cmd.position) < i) begin
            if (i > 0) begin
              cells_next[i] = cells[(i > 0) ? i - 1 : 0];
            end
          end
        end
        aide_pkg::OP_DELETE: begin
          if (flags.found && !lowmask[i] && (i < DEPTH - 1)) begin
            cells_next[i] = cells[(i < DEPTH - 1) ? i + 1 : i];
          end
        end
        aide_pkg::OP_ROTATE: begin
          if (int'(count) == i + 1) begin
            cells_next[i] = cells[0];
          end else if ((int'(count) > i + 1) && (i < DEPTH - 1)) begin
            cells_next[i] = cells[(i < DEPTH - 1) ? i + 1 : i];
          end
        end
        default: begin
          cells_next[i] = cells[i];
        end
      endcase
    end

    always_ff @(posedge clk) begin
      cells[i] <= cells_next[i];
    end
  end

  always_comb begin
    count_next = count;
    unique case (cmd.op)
      aide_pkg::OP_INSERT: count_next = count + CW'(1);
      aide_pkg::OP_DELETE: count_next = count - CW'(1);
      default:             count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

endmodule

[src/aide_ctrl.sv]
// Controller: input handshake, dump sequencer and registered result stage.
// Depends on aide_pkg; drives commands into aide_dp and reads its status.
module aide_ctrl #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32,
  parameter int CW         = 5,
  parameter int IW         = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [aide_pkg::KIND_W-1:0]         kind,
  input  logic [aide_pkg::POS_W-1:0]          position,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [aide_pkg::STATUS_W-1:0]       status,
  output logic signed [aide_pkg::VALUE_W-1:0] entry_value,
  output logic [aide_pkg::EIDX_W-1:0]         entry_index,
  output logic [aide_pkg::FILL_W-1:0]         fill_count,
  output logic                                last,
  output aide_pkg::cmd_t                      cmd,
  input  aide_pkg::flags_t                    flags,
  input  logic [CW-1:0]                       count,
  input  logic [IW-1:0]                       match_idx,
  input  logic [DATA_WIDTH-1:0]               head
);

  localparam int VW   = aide_pkg::VALUE_W;
  localparam int SW   = aide_pkg::STATUS_W;
  localparam int XW   = aide_pkg::EIDX_W;
  localparam int FW   = aide_pkg::FILL_W;
  localparam int CMPW = (CW > aide_pkg::POS_W) ? CW : aide_pkg::POS_W;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DUMP = 1'b1;

  logic          state;
  logic          state_next;
  logic [CW-1:0] didx;
  logic [CW-1:0] didx_next;
  logic          in_acc;
  logic          slot_free;
  logic          load;
  logic          dump_last;
  logic [SW-1:0] status_next;
  logic [VW-1:0] value_next;
  logic [XW-1:0] index_next;
  logic [FW-1:0] fill_next;
  logic          last_next;

  assign slot_free = !out_valid || !out_stall;
  assign in_stall  = (state != ST_IDLE) || !slot_free;
  assign in_acc    = in_valid && !in_stall;
  assign dump_last = (didx == count - CW'(1));

  always_comb begin
    state_next  = state;
    didx_next   = didx;
    load        = 1'b0;
    cmd.op      = aide_pkg::OP_NONE;
    cmd.position = position;
    status_next = aide_pkg::ST_DONE;
    value_next  = '0;
    index_next  = '0;
    fill_next   = FW'(count);
    last_next   = 1'b1;
    unique case (state)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (kind)
            aide_pkg::KIND_DUMP: begin
              if (flags.empty) begin
                load        = 1'b1;
                status_next = aide_pkg::ST_EMPTY;
              end else begin
                state_next = ST_DUMP;
                didx_next  = '0;
              end
            end
            aide_pkg::KIND_DELETE: begin
              load = 1'b1;
              if (flags.found) begin
                cmd.op      = aide_pkg::OP_DELETE;
                status_next = aide_pkg::ST_DONE;
                index_next  = XW'(match_idx);
                fill_next   = FW'(count - CW'(1));
              end else begin
                status_next = aide_pkg::ST_NOT_FOUND;
              end
            end
            aide_pkg::KIND_INSERT: begin
              load = 1'b1;
              if (flags.full) begin
                status_next = aide_pkg::ST_FULL;
              end else if (CMPW'(position) > CMPW'(count)) begin
                status_next = aide_pkg::ST_RANGE;
              end else begin
                cmd.op      = aide_pkg::OP_INSERT;
                status_next = aide_pkg::ST_DONE;
                index_next  = XW'(position);
                fill_next   = FW'(count + CW'(1));
              end
            end
            default: begin
              load = 1'b0;
            end
          endcase
        end
      end
      ST_DUMP: begin
        if (slot_free) begin
          load        = 1'b1;
          cmd.op      = aide_pkg::OP_ROTATE;
          status_next = aide_pkg::ST_ENTRY;
          value_next  = VW'(head);
          index_next  = XW'(didx);
          last_next   = dump_last;
          didx_next   = didx + CW'(1);
          if (dump_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      didx      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      didx  <= didx_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status      <= status_next;
      entry_value <= value_next;
      entry_index <= index_next;
      fill_count  <= fill_next;
      last        <= last_next;
    end
  end

  a_dump_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == ST_DUMP |-> !flags.empty)
    else $error("dump in progress with an empty store");

  a_dump_index: assert property (@(posedge clk) disable iff (rst)
    state == ST_DUMP |-> didx < count)
    else $error("dump index beyond the fill count");

  a_dump_blocks_input: assert property (@(posedge clk) disable iff (rst)
    state == ST_DUMP |-> in_stall)
    else $error("input taken during a dump");

  a_delete_count: assert property (@(posedge clk) disable iff (rst)
    (in_acc && kind == aide_pkg::KIND_DELETE && flags.found) |=>
      count == $past(count) - CW'(1))
    else $error("count not reduced after a delete");

  a_no_load_while_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !load)
    else $error("result overwritten while stalled");

endmodule

[src/array_insert_delete_engine_core.sv]
// Top level of the array insert/delete engine: joins the controller and the datapath.
// Depends on aide_pkg, aide_ctrl and aide_dp.
//
// An ordered store of up to DEPTH words with a fill count. Each input transaction carries
// kind, value and position: insert places value at position and moves later words up, delete
// removes the first word equal to value and moves later words down, dump reads every word out.
// Both channels use valid and stall; a transaction moves when valid is high and stall is low.
// Insert and delete: the transaction is accepted, the store changes at the same
// edge, and the single result appears registered on the output on the next cycle.
// A dump of n words gives n results, one per cycle while the receiver does not stall. On
// acceptance the controller enters its dump state, then loads each result from the first cell
// as the store rotates once per result, so input stays stalled until the last one is loaded.
// Kind three is accepted and gives no result. Every other item ends with last set.
// The input is stalled while a result is held by a stalled receiver, so one result register
// carries the whole output side and nothing is dropped or repeated.
// Reset clears the fill count and the control state; the word cells are not cleared,
// since only words below the fill count are ever read.
module array_insert_delete_engine_core #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [aide_pkg::KIND_W-1:0]         kind,
  input  logic signed [aide_pkg::VALUE_W-1:0] value,
  input  logic [aide_pkg::POS_W-1:0]          position,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [aide_pkg::STATUS_W-1:0]       status,
  output logic signed [aide_pkg::VALUE_W-1:0] entry_value,
  output logic [aide_pkg::EIDX_W-1:0]         entry_index,
  output logic [aide_pkg::FILL_W-1:0]         fill_count,
  output logic                                last
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  aide_pkg::cmd_t        cmd;
  aide_pkg::flags_t      flags;
  logic [CW-1:0]         count;
  logic [IW-1:0]         match_idx;
  logic [DATA_WIDTH-1:0] head;

  aide_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .CW         (CW),
    .IW         (IW)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .kind        (kind),
    .position    (position),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .entry_value (entry_value),
    .entry_index (entry_index),
    .fill_count  (fill_count),
    .last        (last),
    .cmd         (cmd),
    .flags       (flags),
    .count       (count),
    .match_idx   (match_idx),
    .head        (head)
  );

  aide_dp #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .CW         (CW),
    .IW         (IW)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .value     (value),
    .flags     (flags),
    .count     (count),
    .match_idx (match_idx),
    .head      (head)
  );

endmodule

[dv/testbench.sv]
// Self-checking testbench for array_insert_delete_engine_core, the ordered store with
// insert-at-position, delete-by-value and dump. Depends on aide_pkg and the RTL in src.
// A scoreboard mirrors the store, predicts every result and checks each output transaction.
module testbench;

  localparam logic [aide_pkg::KIND_W-1:0] KIND_NOP = 2'd3;
  localparam int STORE_DEPTH = 16;
  localparam int IDLE_LIMIT = 3000;

  typedef struct {
    logic [aide_pkg::STATUS_W-1:0]       status;
    logic signed [aide_pkg::VALUE_W-1:0] word;
    logic [aide_pkg::EIDX_W-1:0]         index;
    logic [aide_pkg::FILL_W-1:0]         fill;
    logic                                last;
  } reply_t;

  logic                                clk;
  logic                                rst;
  logic                                in_valid;
  logic                                in_stall;
  logic [aide_pkg::KIND_W-1:0]         kind;
  logic signed [aide_pkg::VALUE_W-1:0] value;
  logic [aide_pkg::POS_W-1:0]          position;
  logic                                out_valid;
  logic                                out_stall;
  logic [aide_pkg::STATUS_W-1:0]       status;
  logic signed [aide_pkg::VALUE_W-1:0] entry_value;
  logic [aide_pkg::EIDX_W-1:0]         entry_index;
  logic [aide_pkg::FILL_W-1:0]         fill_count;
  logic                                last;

  logic signed [aide_pkg::VALUE_W-1:0] store_words [STORE_DEPTH];
  int                                  held;
  reply_t                              due_replies[$];
  int                                  mismatches;
  int                                  burst_left;
  int                                  hold_request;

  array_insert_delete_engine_core #(
    .DEPTH(STORE_DEPTH),
    .DATA_WIDTH(aide_pkg::VALUE_W)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .kind(kind),
    .value(value),
    .position(position),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status),
    .entry_value(entry_value),
    .entry_index(entry_index),
    .fill_count(fill_count),
    .last(last)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic logic [aide_pkg::POS_W-1:0] rand_pos(int hi);
    int r;
    r = $urandom_range(0, hi);
    return r[aide_pkg::POS_W-1:0];
  endfunction

  function automatic void push_reply(logic [aide_pkg::STATUS_W-1:0] st,
                                     logic signed [aide_pkg::VALUE_W-1:0] w,
                                     int idx, int fill, logic lst);
    reply_t r;
    r.status = st;
    r.word   = w;
    r.index  = idx[aide_pkg::EIDX_W-1:0];
    r.fill   = fill[aide_pkg::FILL_W-1:0];
    r.last   = lst;
    due_replies.push_back(r);
  endfunction

  // Applies one accepted command to the mirrored store and queues the replies it causes.
  function automatic void apply_command(logic [aide_pkg::KIND_W-1:0] k,
                                        logic signed [aide_pkg::VALUE_W-1:0] v,
                                        logic [aide_pkg::POS_W-1:0] p);
    int at;
    at = -1;
    case (k)
      aide_pkg::KIND_DUMP: begin
        if (held == 0) begin
          push_reply(aide_pkg::ST_EMPTY, '0, 0, 0, 1'b1);
        end else begin
          for (int i = 0; i < held; i++) begin
            push_reply(aide_pkg::ST_ENTRY, store_words[i], i, held, i == held - 1);
          end
        end
      end
      aide_pkg::KIND_DELETE: begin
        for (int i = 0; i < held; i++) begin
          if (at < 0 && store_words[i] == v) at = i;
        end
        if (at < 0) begin
          push_reply(aide_pkg::ST_NOT_FOUND, '0, 0, held, 1'b1);
        end else begin
          for (int i = at; i + 1 < held; i++) store_words[i] = store_words[i + 1];
          held--;
          push_reply(aide_pkg::ST_DONE, '0, at, held, 1'b1);
        end
      end
      aide_pkg::KIND_INSERT: begin
        if (held >= STORE_DEPTH) begin
          push_reply(aide_pkg::ST_FULL, '0, 0, held, 1'b1);
        end else if (int'(p) > held) begin
          push_reply(aide_pkg::ST_RANGE, '0, 0, held, 1'b1);
        end else begin
          for (int i = held; i > int'(p); i--) store_words[i] = store_words[i - 1];
          store_words[p] = v;
          held++;
          push_reply(aide_pkg::ST_DONE, '0, p, held, 1'b1);
        end
      end
      default: begin
      end
    endcase
  endfunction

  // Offers one command until it is accepted; when a burst runs out, idles before the next burst.
  task automatic send_command(logic [aide_pkg::KIND_W-1:0] k,
                              logic signed [aide_pkg::VALUE_W-1:0] v,
                              logic [aide_pkg::POS_W-1:0] p);
    in_valid <= 1'b1;
    kind     <= k;
    value    <= v;
    position <= p;
    do @(posedge clk); while (in_stall !== 1'b0);
    apply_command(k, v, p);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 10);
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic drain_replies();
    in_valid <= 1'b0;
    while (due_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic test_empty_store();
    send_command(aide_pkg::KIND_DUMP, 32'sd0, 5'd0);
    send_command(aide_pkg::KIND_DELETE, 32'sd7, 5'd0);
    send_command(aide_pkg::KIND_INSERT, 32'sd9, 5'd1);
    send_command(KIND_NOP, -32'sd1, 5'd31);
    drain_replies();
  endtask

  task automatic test_fill_to_full();
    logic signed [aide_pkg::VALUE_W-1:0] fill_words [STORE_DEPTH] = '{
      32'sh80000000, 32'sh7fffffff, 32'sd0, -32'sd1, 32'sd5, 32'sd5, 32'sd1, -32'sd2,
      32'sh55555555, 32'shaaaaaaaa, 32'sd5, 32'sd100, -32'sd100, 32'sh00010000,
      32'sh7ffffffe, 32'sh80000001};
    int p;
    for (int i = 0; i < STORE_DEPTH; i++) begin
      p = (i % 3 == 0) ? 0 : (i % 3 == 1) ? i : i / 2;
      send_command(aide_pkg::KIND_INSERT, fill_words[i], p[aide_pkg::POS_W-1:0]);
    end
    send_command(aide_pkg::KIND_INSERT, 32'sd42, 5'd16);
    send_command(aide_pkg::KIND_DUMP, 32'sd0, 5'd0);
    drain_replies();
  endtask

  task automatic test_delete_cases();
    send_command(aide_pkg::KIND_DELETE, 32'sd5, 5'd0);
    send_command(aide_pkg::KIND_DELETE, store_words[held - 1], 5'd0);
    send_command(aide_pkg::KIND_DELETE, 32'sh80000000, 5'd0);
    send_command(aide_pkg::KIND_DELETE, 32'sd12345, 5'd0);
    send_command(aide_pkg::KIND_INSERT, 32'sd3, 5'd16);
    drain_replies();
  endtask

  task automatic test_random_traffic(int n_items);
    int                                  sent;
    int                                  pick;
    bit                                  growing;
    logic [aide_pkg::KIND_W-1:0]         k;
    logic signed [aide_pkg::VALUE_W-1:0] v;
    logic [aide_pkg::POS_W-1:0]          p;
    sent    = 0;
    growing = 1'b1;
    while (sent < n_items) begin
      if (held >= 14) growing = 1'b0;
      else if (held <= 2) growing = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 4) k = KIND_NOP;
      else if (pick < 14) k = aide_pkg::KIND_DUMP;
      else if (pick < (growing ? 70 : 34)) k = aide_pkg::KIND_INSERT;
      else k = aide_pkg::KIND_DELETE;
      if ($urandom_range(0, 1) == 1) v = $urandom;
      else v = $signed(32'($urandom_range(0, 7))) - 32'sd4;
      if ($urandom_range(0, 9) == 0) p = rand_pos(16);
      else p = rand_pos(held);
      if (k == aide_pkg::KIND_DELETE && held > 0 && $urandom_range(0, 3) != 0) begin
        v = store_words[$urandom_range(0, held - 1)];
      end
      send_command(k, v, p);
      if (k != KIND_NOP) sent++;
      if ($urandom_range(0, 39) == 0) drain_replies();
    end
    drain_replies();
  endtask

  task automatic test_receiver_hold();
    hold_request = 150;
    for (int i = 0; i < 14; i++) begin
      if (i % 5 == 4) send_command(aide_pkg::KIND_DUMP, 32'sd0, 5'd0);
      else if (i % 3 == 2) send_command(aide_pkg::KIND_DELETE, store_words[0], 5'd0);
      else send_command(aide_pkg::KIND_INSERT, $urandom, rand_pos(held));
    end
    drain_replies();
  endtask

  // Receiver: stalls on a changing pattern, or for a long stretch when a test asks.
  initial begin
    int mode;
    int mode_left;
    int hold_left;
    int phase;
    logic stall;
    out_stall <= 1'b0;
    mode      = 0;
    mode_left = 0;
    hold_left = 0;
    phase     = 0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        stall = 1'b1;
      end else begin
        if (mode_left <= 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(10, 80);
        end
        mode_left--;
        phase++;
        case (mode)
          0: stall = 1'b0;
          1: stall = ($urandom_range(0, 3) == 0);
          2: stall = ($urandom_range(0, 3) != 0);
          default: stall = (phase % 5 < 2);
        endcase
      end
      out_stall <= stall;
    end
  end

  // Checks each output transaction against the oldest predicted reply.
  always @(posedge clk) begin
    reply_t exp;
    if (!rst && out_valid && !out_stall) begin
      if (due_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Unexpected result: status %0d value %0d index %0d fill %0d last %0b",
                   status, entry_value, entry_index, fill_count, last);
        end
      end else begin
        exp = due_replies.pop_front();
        if (status !== exp.status || entry_value !== exp.word || entry_index !== exp.index ||
            fill_count !== exp.fill || last !== exp.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Mismatch: expected status %0d value %0d index %0d fill %0d last %0b",
                     exp.status, exp.word, exp.index, exp.fill, exp.last);
            $display("          actual   status %0d value %0d index %0d fill %0d last %0b",
                     status, entry_value, entry_index, fill_count, last);
          end
        end
      end
    end
  end

  // Watchdog: ends the run when no transaction has moved for too long.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    rst          <= 1'b1;
    in_valid     <= 1'b0;
    kind         <= aide_pkg::KIND_DUMP;
    value        <= '0;
    position     <= '0;
    held         = 0;
    mismatches   = 0;
    burst_left   = 5;
    hold_request = 0;
    for (int i = 0; i < STORE_DEPTH; i++) store_words[i] = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_empty_store();
    test_fill_to_full();
    test_delete_cases();
    test_receiver_hold();
    test_random_traffic(280);
    drain_replies();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
